// ===== sv/stsm_pkg.sv =====
`timescale 1ns / 1ps

package stsm_pkg;

   // Element count of the tree. Leaf i sits at node LEAVES + i; node k sums 2k and 2k + 1.
   localparam int LEAVES  = 1024;
   localparam int NODES   = 2 * LEAVES;
   localparam int NODE_AW = $clog2(NODES);
   // Working width for node indices, lengths and clipped ranges.
   // It holds 2*LEAVES and every 10- or 11-bit port value.
   localparam int CMP_W   = (NODE_AW + 1 > 11) ? NODE_AW + 1 : 11;

   localparam int DATA_W  = 32;
   localparam int IDX_W   = 10;
   localparam int LEN_W   = 11;
   localparam int CSR_AW  = 3;

   localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

   // Register byte addresses, decoded on paddr[2].
   localparam logic REG_LENGTH = 1'b0;

   localparam logic [1:0] MODE_UPDATE = 2'd0;
   localparam logic [1:0] MODE_SUM    = 2'd1;
   localparam logic [1:0] MODE_MAX    = 2'd2;

   typedef logic [CMP_W-1:0]   idx_type;
   typedef logic [NODE_AW-1:0] addr_type;

   // One tree node: partial sum and maximum over the leaves below it.
   typedef struct packed {
      logic signed [DATA_W-1:0] sum;
      logic signed [DATA_W-1:0] max;
   } node_type;

endpackage

// ===== sv/segment_tree_sum_max_store.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_mode, req_position, req_new_value,
//                                          req_range_low, req_range_high
// rsp      out        rsp_valid/rsp_stall  rsp_result_value
// csr      in         psel/penable/pready  length_in_use at byte address 0
//
// One request at a time. The node memory has one write and one read port, read data
// registered. An update writes its leaf and then one ancestor per cycle up to the root.
// A range sum or range max walks the tree from both ends, with one read slot per level
// for the left edge and one for the right. Updates outside the length, empty ranges
// and mode 3 answer 0. After reset a clearing pass zeroes all 2*LEAVES nodes, with
// req_stall high; csr writes are taken throughout. A result waiting on rsp_stall sits
// in the output register while the next request is already accepted and worked on.

module segment_tree_sum_max_store (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [stsm_pkg::IDX_W-1:0]          req_position,
   input  logic signed [stsm_pkg::DATA_W-1:0]  req_new_value,
   input  logic [stsm_pkg::IDX_W-1:0]          req_range_low,
   input  logic [stsm_pkg::IDX_W-1:0]          req_range_high,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [stsm_pkg::DATA_W-1:0]  rsp_result_value,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [stsm_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [2:0] {
      ST_CLEAR,   // zeroing pass after reset
      ST_IDLE,    // waiting for a request
      ST_UPDATE,  // climbing from a written leaf to the root
      ST_LEFT,    // query: left edge of the current level
      ST_RIGHT,   // query: right edge, then move up one level
      ST_DONE     // result ready, waiting for the output register
   } state_type;

   // ---------------------------------------------------------------- node memory
   stsm_pkg::node_type node_mem [stsm_pkg::NODES];
   stsm_pkg::node_type rd_ff;

   logic               mem_we;
   stsm_pkg::addr_type mem_waddr;
   stsm_pkg::node_type mem_wdata;
   logic               mem_re;
   stsm_pkg::addr_type mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= node_mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------- registers
   state_type                         state_ff,    state_in;
   stsm_pkg::addr_type                clr_ff,      clr_in;
   logic [stsm_pkg::LEN_W-1:0]        len_ff,      len_in;
   stsm_pkg::idx_type                 k_ff,        k_in;       // update: current node
   stsm_pkg::node_type                cur_ff,      cur_in;     // update: value of node k
   stsm_pkg::idx_type                 l_ff,        l_in;       // query: left bound
   stsm_pkg::idx_type                 r_ff,        r_in;       // query: right bound, open
   logic                              pend_ff,     pend_in;    // rd_ff holds a node to add
   logic                              is_max_ff,   is_max_in;
   logic signed [stsm_pkg::DATA_W-1:0] acc_sum_ff, acc_sum_in;
   logic signed [stsm_pkg::DATA_W-1:0] acc_max_ff, acc_max_in;
   logic                              have_ff,     have_in;    // acc_max holds a value
   logic signed [stsm_pkg::DATA_W-1:0] res_ff,     res_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [stsm_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------- csr port
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == stsm_pkg::REG_LENGTH) ?
                       {{(32 - stsm_pkg::LEN_W){1'b0}}, len_ff} : 32'd0;

   // ---------------------------------------------------------------- request decode
   logic              accept;
   stsm_pkg::idx_type len_ext, used_len, pos_ext, lo_ext, hi_ext, hi_clip, leaf_idx;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // A length of 0 acts as 1, any length above LEAVES acts as LEAVES.
   assign len_ext  = stsm_pkg::CMP_W'(len_ff);
   assign used_len = (len_ext == '0) ? stsm_pkg::idx_type'(1) :
                     (len_ext > stsm_pkg::idx_type'(stsm_pkg::LEAVES)) ?
                     stsm_pkg::idx_type'(stsm_pkg::LEAVES) : len_ext;
   assign pos_ext  = stsm_pkg::CMP_W'(req_position);
   assign lo_ext   = stsm_pkg::CMP_W'(req_range_low);
   assign hi_ext   = stsm_pkg::CMP_W'(req_range_high);
   assign hi_clip  = (hi_ext > used_len - 1'b1) ? used_len - 1'b1 : hi_ext;
   assign leaf_idx = pos_ext + stsm_pkg::idx_type'(stsm_pkg::LEAVES);

   // ---------------------------------------------------------------- datapath
   stsm_pkg::idx_type  parent;
   stsm_pkg::node_type merged;
   logic signed [stsm_pkg::DATA_W-1:0] add_sum, add_max;
   logic                               add_have;
   logic                               out_free;

   assign parent       = k_ff >> 1;
   assign merged.sum   = cur_ff.sum + rd_ff.sum;
   assign merged.max   = (rd_ff.max > cur_ff.max) ? rd_ff.max : cur_ff.max;

   // Query accumulator with the node that arrived from memory this cycle.
   assign add_sum  = pend_ff ? acc_sum_ff + rd_ff.sum : acc_sum_ff;
   assign add_max  = !pend_ff ? acc_max_ff :
                     (!have_ff || rd_ff.max > acc_max_ff) ? rd_ff.max : acc_max_ff;
   assign add_have = have_ff || pend_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      pend_in      = pend_ff;
      is_max_in    = is_max_ff;
      acc_sum_in   = acc_sum_ff;
      acc_max_in   = acc_max_ff;
      have_in      = have_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;

      if (csr_write && csr_paddr[2] == stsm_pkg::REG_LENGTH) begin
         len_in = csr_pwdata[stsm_pkg::LEN_W-1:0];
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == stsm_pkg::addr_type'(stsm_pkg::NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               res_in   = '0;
               state_in = ST_DONE;
               case (req_mode)
                  stsm_pkg::MODE_UPDATE: begin
                     if (pos_ext < used_len) begin
                        // write the leaf, fetch its sibling
                        mem_we        = 1'b1;
                        mem_waddr     = leaf_idx[stsm_pkg::NODE_AW-1:0];
                        mem_wdata.sum = req_new_value;
                        mem_wdata.max = req_new_value;
                        mem_re        = 1'b1;
                        mem_raddr     = leaf_idx[stsm_pkg::NODE_AW-1:0] ^ 1'b1;
                        k_in          = leaf_idx;
                        cur_in.sum    = req_new_value;
                        cur_in.max    = req_new_value;
                        state_in      = ST_UPDATE;
                     end
                  end
                  stsm_pkg::MODE_SUM, stsm_pkg::MODE_MAX: begin
                     if (lo_ext <= hi_clip) begin
                        l_in       = lo_ext + stsm_pkg::idx_type'(stsm_pkg::LEAVES);
                        r_in       = hi_clip + stsm_pkg::idx_type'(stsm_pkg::LEAVES + 1);
                        pend_in    = 1'b0;
                        acc_sum_in = '0;
                        acc_max_in = '0;
                        have_in    = 1'b0;
                        is_max_in  = (req_mode == stsm_pkg::MODE_MAX);
                        state_in   = ST_LEFT;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_UPDATE: begin
            // rd_ff is the sibling of node k: write the parent, fetch its sibling
            mem_we    = 1'b1;
            mem_waddr = parent[stsm_pkg::NODE_AW-1:0];
            mem_wdata = merged;
            cur_in    = merged;
            k_in      = parent;
            if (parent == stsm_pkg::idx_type'(1)) begin
               res_in   = '0;
               state_in = ST_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = parent[stsm_pkg::NODE_AW-1:0] ^ 1'b1;
            end
         end

         ST_LEFT: begin
            acc_sum_in = add_sum;
            acc_max_in = add_max;
            have_in    = add_have;
            pend_in    = 1'b0;
            if (l_ff < r_ff) begin
               if (l_ff[0]) begin
                  mem_re    = 1'b1;
                  mem_raddr = l_ff[stsm_pkg::NODE_AW-1:0];
                  l_in      = l_ff + 1'b1;
                  pend_in   = 1'b1;
               end
               state_in = ST_RIGHT;
            end else begin
               res_in   = is_max_ff ? add_max : add_sum;
               state_in = ST_DONE;
            end
         end

         ST_RIGHT: begin
            acc_sum_in = add_sum;
            acc_max_in = add_max;
            have_in    = add_have;
            pend_in    = 1'b0;
            if (r_ff[0]) begin
               mem_re    = 1'b1;
               mem_raddr = r_ff[stsm_pkg::NODE_AW-1:0] - 1'b1;
               pend_in   = 1'b1;
            end
            // odd r: (r - 1) >> 1 equals r >> 1
            l_in     = l_ff >> 1;
            r_in     = r_ff >> 1;
            state_in = ST_LEFT;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         len_ff       <= stsm_pkg::LEN_RESET;
         pend_ff      <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      is_max_ff   <= is_max_in;
      acc_sum_ff  <= acc_sum_in;
      acc_max_ff  <= acc_max_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_data_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for segment_tree_sum_max_store.
// A mirror of the element array predicts every answer. Sums are taken directly over
// the clipped range, so the tree inside the block is checked against plain arithmetic.

module testbench;

   // Mode 3 has no operation; the block answers 0 and changes nothing.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // Byte address of register 0 (length in use).
   localparam logic [stsm_pkg::CSR_AW-1:0] LENGTH_ADDR = {stsm_pkg::REG_LENGTH, 2'b00};
   localparam int IDX_MAX = (1 << stsm_pkg::IDX_W) - 1;
   localparam int RANDOM_PER_PHASE = 100;

   typedef struct {
      logic [1:0]                         mode;
      logic [stsm_pkg::IDX_W-1:0]         position;
      logic signed [stsm_pkg::DATA_W-1:0] new_value;
      logic [stsm_pkg::IDX_W-1:0]         range_low;
      logic [stsm_pkg::IDX_W-1:0]         range_high;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [1:0]                         req_mode = stsm_pkg::MODE_UPDATE;
   logic [stsm_pkg::IDX_W-1:0]         req_position = '0;
   logic signed [stsm_pkg::DATA_W-1:0] req_new_value = '0;
   logic [stsm_pkg::IDX_W-1:0]         req_range_low = '0;
   logic [stsm_pkg::IDX_W-1:0]         req_range_high = '0;

   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [stsm_pkg::DATA_W-1:0] rsp_result_value;

   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [stsm_pkg::CSR_AW-1:0]        csr_paddr = '0;
   logic [31:0]                        csr_pwdata = '0;
   logic [31:0]                        csr_prdata;
   logic                               csr_pready;

   // Mirror of the block's state and its one register.
   logic signed [stsm_pkg::DATA_W-1:0] element_mirror [stsm_pkg::LEAVES];
   logic [stsm_pkg::LEN_W-1:0]         length_setting = stsm_pkg::LEN_RESET;

   request_type                        pending_requests[$];
   logic signed [stsm_pkg::DATA_W-1:0] pending_answers[$];
   request_type                        on_wire;

   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int free_left = 0;

   int mode_count[4] = '{0, 0, 0, 0};
   int skipped_updates = 0;
   int answers_checked = 0;
   int mismatches = 0;
   int settings_used = 1;

   // Length settings for the random phases; the extremes 0, 1, 1024 and 2047 are in.
   int unsigned phase_lengths[12] = '{1024, 1, 2, 3, 16, 0, 2047, 0, 1000, 1023, 1025, 1024};

   segment_tree_sum_max_store dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_position     (req_position),
      .req_new_value    (req_new_value),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // 0 acts as 1, anything above LEAVES acts as LEAVES.
   function automatic int unsigned effective_length(
         input logic [stsm_pkg::LEN_W-1:0] setting);
      if (setting == 0) return 1;
      if (setting > stsm_pkg::LEAVES) return stsm_pkg::LEAVES;
      return 32'(setting);
   endfunction

   // Applies one request to the mirror and returns the answer the block must give.
   function automatic logic signed [stsm_pkg::DATA_W-1:0] compute_answer(
         input request_type r);
      int unsigned n;
      int unsigned top;
      logic signed [stsm_pkg::DATA_W-1:0] acc;
      n = effective_length(length_setting);
      top = (r.range_high > n - 1) ? n - 1 : 32'(r.range_high);
      acc = '0;
      case (r.mode)
         stsm_pkg::MODE_UPDATE: begin
            if (r.position < n) element_mirror[r.position] = r.new_value;
         end
         stsm_pkg::MODE_SUM: begin
            if (r.range_low <= top)
               for (int i = r.range_low; i <= top; i++) acc += element_mirror[i];
         end
         stsm_pkg::MODE_MAX: begin
            if (r.range_low <= top) begin
               acc = element_mirror[r.range_low];
               for (int i = r.range_low + 1; i <= top; i++)
                  if (element_mirror[i] > acc) acc = element_mirror[i];
            end
         end
         default: ;
      endcase
      return acc;
   endfunction

   task automatic queue_request(input logic [1:0] m, input logic [stsm_pkg::IDX_W-1:0] p,
                                input logic [stsm_pkg::DATA_W-1:0] v,
                                input logic [stsm_pkg::IDX_W-1:0] lo,
                                input logic [stsm_pkg::IDX_W-1:0] hi);
      request_type r;
      r.mode = m;
      r.position = p;
      r.new_value = v;
      r.range_low = lo;
      r.range_high = hi;
      pending_requests.push_back(r);
   endtask

   // Values lean on the 32-bit extremes so that sums wrap often.
   function automatic logic [stsm_pkg::DATA_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3: return '1;
         4: return stsm_pkg::DATA_W'($urandom_range(0, 200) - 100);
         default: return stsm_pkg::DATA_W'($urandom);
      endcase
   endfunction

   // Mostly inside the length in use, sometimes anywhere in the index range.
   function automatic logic [stsm_pkg::IDX_W-1:0] random_index(input int unsigned n);
      if ($urandom_range(0, 4) == 0) return stsm_pkg::IDX_W'($urandom_range(0, IDX_MAX));
      return stsm_pkg::IDX_W'($urandom_range(0, n - 1));
   endfunction

   function automatic request_type random_request();
      request_type r;
      int unsigned n;
      int pick;
      logic [stsm_pkg::IDX_W-1:0] swap;
      n = effective_length(length_setting);
      // garbage in the fields the operation does not use
      r.position = stsm_pkg::IDX_W'($urandom_range(0, IDX_MAX));
      r.new_value = stsm_pkg::DATA_W'($urandom);
      r.range_low = stsm_pkg::IDX_W'($urandom_range(0, IDX_MAX));
      r.range_high = stsm_pkg::IDX_W'($urandom_range(0, IDX_MAX));
      pick = $urandom_range(0, 19);
      if (pick < 8) r.mode = stsm_pkg::MODE_UPDATE;
      else if (pick < 13) r.mode = stsm_pkg::MODE_SUM;
      else if (pick < 18) r.mode = stsm_pkg::MODE_MAX;
      else if (pick == 18) r.mode = MODE_UNUSED;
      else r.mode = 2'($urandom_range(0, 3));
      if (r.mode == stsm_pkg::MODE_UPDATE) begin
         r.position = random_index(n);
         r.new_value = random_value();
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 9) begin
            r.range_low = random_index(n);
            r.range_high = random_index(n);
         end
         // mostly ordered, some reversed (empty), some single-element
         if (pick < 7 && r.range_low > r.range_high) begin
            swap = r.range_low;
            r.range_low = r.range_high;
            r.range_high = swap;
         end else if (pick == 8) begin
            r.range_high = r.range_low;
         end
      end
      return r;
   endfunction

   // APB write: setup cycle, then access cycle; taken at the edge with pready high.
   task automatic write_length(input logic [stsm_pkg::LEN_W-1:0] setting);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LENGTH_ADDR;
      csr_pwdata <= 32'(setting);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      length_setting = setting;
      settings_used++;
      @(negedge clock);
   endtask

   // Block is idle once every request is in and every answer is back.
   task automatic drain();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || pending_answers.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_answers.push_back(compute_answer(on_wire));
            mode_count[on_wire.mode]++;
            if (on_wire.mode == stsm_pkg::MODE_UPDATE &&
                on_wire.position >= effective_length(length_setting))
               skipped_updates++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled request as it is
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            on_wire = pending_requests.pop_front();
            req_mode <= on_wire.mode;
            req_position <= on_wire.position;
            req_new_value <= on_wire.new_value;
            req_range_low <= on_wire.range_low;
            req_range_high <= on_wire.range_high;
            req_valid <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Answer monitor; the stall pattern alternates free stretches (some long) with stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: answer %0d with no request outstanding", $time, rsp_result_value);
               mismatches++;
            end else begin
               if (rsp_result_value !== pending_answers[0]) begin
                  $display("%0t: result_value expected %0d (%h), got %0d (%h)", $time,
                           pending_answers[0], pending_answers[0],
                           rsp_result_value, rsp_result_value);
                  mismatches++;
               end
               void'(pending_answers.pop_front());
               answers_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else begin
            free_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            stall_left = $urandom_range(1, 10);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      foreach (element_mirror[k]) element_mirror[k] = '0;
      phase_lengths[5] = $urandom_range(4, 1022);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Full length after reset: extremes, wrapped sum, empty ranges, unused mode.
      queue_request(stsm_pkg::MODE_UPDATE, 10'd0, 32'h7FFF_FFFF, '0, '0);
      queue_request(stsm_pkg::MODE_UPDATE, 10'd1023, 32'h8000_0000, '1, '1);
      queue_request(stsm_pkg::MODE_UPDATE, 10'd512, 32'hFFFF_FFFF, '0, '1);
      queue_request(stsm_pkg::MODE_SUM, '1, '1, 10'd0, 10'd1023);
      queue_request(stsm_pkg::MODE_MAX, '0, '0, 10'd0, 10'd1023);
      queue_request(stsm_pkg::MODE_MAX, '0, '0, 10'd1, 10'd1023);
      queue_request(stsm_pkg::MODE_MAX, '0, '0, 10'd1023, 10'd1023);
      queue_request(stsm_pkg::MODE_SUM, '0, '0, 10'd600, 10'd3);
      queue_request(stsm_pkg::MODE_MAX, '0, '0, 10'd1023, 10'd0);
      queue_request(MODE_UNUSED, 10'd7, 32'd99, 10'd0, 10'd1023);
      queue_request(stsm_pkg::MODE_SUM, '0, '0, 10'd7, 10'd7);
      queue_request(stsm_pkg::MODE_UPDATE, 10'd1, 32'h7FFF_FFFF, '0, '0);
      queue_request(stsm_pkg::MODE_SUM, '0, '0, 10'd0, 10'd1);
      drain();

      // Length 0 acts as 1: writes past it are dropped, ranges clip to element 0.
      write_length(11'd0);
      queue_request(stsm_pkg::MODE_UPDATE, 10'd1, 32'd55, '0, '0);
      queue_request(stsm_pkg::MODE_UPDATE, 10'd0, -32'sd7, '0, '0);
      queue_request(stsm_pkg::MODE_SUM, '0, '0, 10'd0, 10'd1023);
      queue_request(stsm_pkg::MODE_MAX, '0, '0, 10'd3, 10'd1023);
      queue_request(stsm_pkg::MODE_MAX, '0, '0, 10'd0, 10'd0);
      drain();

      // Above LEAVES acts as LEAVES; tree sums must still hold.
      write_length(11'd2047);
      queue_request(stsm_pkg::MODE_SUM, '0, '0, 10'd0, 10'd1023);
      queue_request(stsm_pkg::MODE_SUM, '0, '0, 10'd1, 10'd1);
      drain();

      // Short length: update at the length is dropped, range high clips.
      write_length(11'd5);
      queue_request(stsm_pkg::MODE_UPDATE, 10'd5, 32'd1234, '0, '0);
      queue_request(stsm_pkg::MODE_UPDATE, 10'd4, 32'h8000_0000, '0, '0);
      queue_request(stsm_pkg::MODE_SUM, '0, '0, 10'd3, 10'd1023);
      queue_request(stsm_pkg::MODE_MAX, '0, '0, 10'd0, 10'd9);
      queue_request(stsm_pkg::MODE_MAX, '0, '0, 10'd5, 10'd9);
      drain();

      // Random phases, one per length setting.
      foreach (phase_lengths[p]) begin
         write_length(phase_lengths[p][stsm_pkg::LEN_W-1:0]);
         repeat (RANDOM_PER_PHASE) pending_requests.push_back(random_request());
         drain();
      end

      // Room for any stray answer after the last one.
      repeat (50) @(posedge clock);
      $display("%0d requests: %0d updates (%0d past the length), %0d sums, %0d maxima, %0d idle",
               mode_count[stsm_pkg::MODE_UPDATE] + mode_count[stsm_pkg::MODE_SUM] +
               mode_count[stsm_pkg::MODE_MAX] + mode_count[MODE_UNUSED],
               mode_count[stsm_pkg::MODE_UPDATE], skipped_updates,
               mode_count[stsm_pkg::MODE_SUM], mode_count[stsm_pkg::MODE_MAX],
               mode_count[MODE_UNUSED]);
      $display("%0d answers checked across %0d length settings, %0d mismatches",
               answers_checked, settings_used, mismatches);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("CHECK OK");
      end else begin
         if (pending_answers.size() != 0)
            $display("%0d answers never arrived", pending_answers.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest correct run including the clearing pass.
   initial begin
      #15_000_000;
      $display("timeout with %0d requests and %0d answers outstanding",
               pending_requests.size(), pending_answers.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
